// File: hdl/lpra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpra_pkg
// Types and constants shared by the lidar point to image box association block.
// ----------------------------------------------------------------------------
package lpra_pkg;

  localparam int unsigned CfgW = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MaxBoxes = 64;

  localparam logic [CfgIdxW-1:0] RegRow0Lo = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow0Hi = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow1Lo = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow1Hi = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRow2Lo = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRow2Hi = 3'd5;
  localparam logic [CfgIdxW-1:0] RegShrink = 3'd6;
  localparam logic [CfgIdxW-1:0] RegActive = 3'd7;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncPoint = 1'b1;

  localparam logic [1:0] StNone = 2'd0;
  localparam logic [1:0] StOne = 2'd1;
  localparam logic [1:0] StMany = 2'd2;
  localparam logic [1:0] StBehind = 2'd3;

  // Stored box: left and top of 13 bits, width and height of 12 bits.
  typedef struct packed {
    logic [12:0] left;
    logic [12:0] top;
    logic [11:0] width;
    logic [11:0] height;
  } box_t;

  typedef struct packed {
    logic        func;
    logic [5:0]  box_slot;
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [11:0] box_width;
    logic [11:0] box_height;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  box_index;
    logic [6:0]  enclosing_count;
    logic signed [15:0] pixel_u;
    logic signed [15:0] pixel_v;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD_MUL, S_LOAD_WR, S_PROJ, S_DIV_START, S_DIV, S_SCAN, S_SCAN_LAST,
    S_OUT
  } state_e;

endpackage

// File: hdl/lpra_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpra_div
// Radix-2 restoring divider for signed dividends and positive divisors,
// truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpra_div import lpra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [63:0]        den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;
  logic [63:0] quo_step;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (start_i) begin
      neg_d = num_i[63];
      quo_d = num_i[63] ? 64'(-num_i) : 64'(num_i);
      rem_d = '0;
      den_d = den_i;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
      end
      quo_d = quo_step;
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  assign quo_step = {quo_q[62:0], ~trial[64]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quo_o = neg_q ? -$signed(quo_step) : $signed(quo_step);

endmodule

// File: hdl/lidar_point_roi_association.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_roi_association
// Shrinks and stores image boxes, projects lidar points to pixels and counts
// the stored boxes that contain each projected pixel.
// ----------------------------------------------------------------------------
// A load item passes through S_LOAD_MUL and S_LOAD_WR before the next item is accepted.
// A point item passes through the projection (S_PROJ), a divider start, two
// divisions (u, then v), a scan of the n active boxes (skipped when n is zero)
// and the output state, which holds until the result is taken; a point behind
// the camera skips the divisions and the scan. One item is in work at a time.
// Reset clears the control state and configuration; the box table has no reset.
module lidar_point_roi_association import lpra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  localparam int unsigned AW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int unsigned CW = $clog2(MaxBoxes + 1);

  logic [63:0] mat_q [6];
  logic [8:0]  shrink_q;
  logic [6:0]  active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) mat_q[i] <= '0;
      shrink_q <= '0;
      active_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRow0Lo, RegRow0Hi, RegRow1Lo, RegRow1Hi, RegRow2Lo, RegRow2Hi:
          mat_q[cfg_idx_i] <= cfg_data_i;
        RegShrink: shrink_q <= cfg_data_i[8:0];
        RegActive: active_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  state_e st_q, st_d;
  in_item_t item_q;
  logic signed [63:0] acc_q [3];
  logic signed [63:0] acc_d [3];
  logic signed [15:0] u_q, v_q, u_d, v_d;
  logic [CW-1:0] n_q, idx_q, idx_d;
  logic [6:0] cnt_q, cnt_d;
  logic [5:0] found_q, found_d;
  logic behind_q, behind_d;
  logic div_sel_q, div_sel_d;
  logic [20:0] mw_q, mh_q, sw_q, sh_q;
  logic [8:0] f_eff;
  out_item_t res_q, res_d;

  box_t mem [MaxBoxes];
  box_t rd_q;
  logic mem_we;
  box_t wr_box;

  logic div_start, div_done;
  logic signed [63:0] div_quo;

  assign f_eff = (shrink_q > 9'd256) ? 9'd256 : shrink_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[item_q.box_slot[AW-1:0]] <= wr_box;
    rd_q <= mem[idx_q[AW-1:0]];
  end

  // One signed 32x17 product per cycle, accumulated over four phases.
  logic signed [48:0] prod_q;
  logic [4:0] mstep_q, mstep_d;
  logic [1:0] mrow, mk;
  assign mrow = mstep_q[3:2] == 2'd0 ? 2'd2 : (mstep_q[3:2] == 2'd1 ? 2'd0 : 2'd1);
  assign mk = mstep_q[1:0];
  logic [63:0] mword;
  logic signed [31:0] mcoef;
  logic signed [16:0] mop;
  always_comb begin
    mword = mat_q[{1'b0, mrow} * 3'd2 + {2'b0, mk[1]}];
    mcoef = mk[0] ? mword[63:32] : mword[31:0];
    case (mk)
      2'd0: mop = 17'(item_q.point_x);
      2'd1: mop = 17'(item_q.point_y);
      2'd2: mop = 17'(item_q.point_z);
      default: mop = 17'sd256;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mcoef * mop;
    mw_q <= 21'(f_eff) * 21'(item_q.box_width);
    mh_q <= 21'(f_eff) * 21'(item_q.box_height);
    sw_q <= 21'(9'd256 - f_eff) * 21'(item_q.box_width);
    sh_q <= 21'(9'd256 - f_eff) * 21'(item_q.box_height);
  end

  lpra_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(div_sel_d ? acc_q[1] : acc_q[0]), .den_i(acc_q[2]),
    .done_o(div_done), .quo_o(div_quo)
  );

  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) return 16'sh7fff;
    if (x < -64'sd32768) return -16'sh8000;
    return x[15:0];
  endfunction

  logic signed [16:0] bl, bt, br, bb, su, sv;
  logic hit;
  always_comb begin
    bl = 17'($signed({1'b0, rd_q.left[12:0]}));
    bt = 17'($signed({1'b0, rd_q.top[12:0]}));
    br = bl + 17'($signed({1'b0, rd_q.width}));
    bb = bt + 17'($signed({1'b0, rd_q.height}));
    su = 17'(u_q);
    sv = 17'(v_q);
    hit = (bl <= su) && (su < br) && (bt <= sv) && (sv < bb);
  end

  logic [CW-1:0] n_eff;
  assign n_eff = (active_q > 7'(MaxBoxes)) ? CW'(MaxBoxes) : CW'(active_q);

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_valid_i) st_d = (in_item_i.func == FuncLoad) ? S_LOAD_MUL : S_PROJ;
      S_LOAD_MUL: st_d = S_LOAD_WR;
      S_LOAD_WR: st_d = S_IDLE;
      S_PROJ: if (mstep_q == 5'd12) st_d = S_DIV_START;
      S_DIV_START: st_d = behind_q ? S_OUT : S_DIV;
      S_DIV: if (div_done && div_sel_q) st_d = (n_q == '0) ? S_OUT : S_SCAN;
      S_SCAN: if (idx_q == n_q - CW'(1)) st_d = S_SCAN_LAST;
      S_SCAN_LAST: st_d = S_OUT;
      S_OUT: if (out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we = (st_q == S_LOAD_WR) && (32'(item_q.box_slot) < MaxBoxes);
    wr_box.left = 13'(item_q.box_left) + 13'(mw_q >> 9);
    wr_box.top = 13'(item_q.box_top) + 13'(mh_q >> 9);
    wr_box.width = 12'(sw_q >> 8);
    wr_box.height = 12'(sh_q >> 8);
    div_start = 1'b0;
    div_sel_d = div_sel_q;
    mstep_d = mstep_q;
    acc_d = acc_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    found_d = found_q;
    behind_d = behind_q;
    u_d = u_q;
    v_d = v_q;
    res_d = res_q;
    case (st_q)
      S_IDLE: begin
        mstep_d = '0;
        for (int i = 0; i < 3; i++) acc_d[i] = '0;
      end
      S_PROJ: begin
        mstep_d = mstep_q + 5'd1;
        if (mstep_q != 5'd0) begin
          acc_d[(mstep_q - 5'd1) >> 2 == 5'd0 ? 2 : ((mstep_q - 5'd1) >> 2 == 5'd1 ? 0 : 1)] =
            acc_q[(mstep_q - 5'd1) >> 2 == 5'd0 ? 2 : ((mstep_q - 5'd1) >> 2 == 5'd1 ? 0 : 1)]
            + 64'(prod_q);
        end
        if (mstep_q == 5'd4) behind_d = (acc_d[2] <= 64'sd0);
      end
      S_DIV_START: begin
        div_sel_d = 1'b0;
        div_start = !behind_q;
        idx_d = '0;
        cnt_d = '0;
        found_d = '0;
      end
      S_DIV: if (div_done) begin
        if (!div_sel_q) begin
          u_d = sat16(div_quo);
          div_sel_d = 1'b1;
          div_start = 1'b1;
        end else begin
          v_d = sat16(div_quo);
        end
      end
      S_SCAN: begin
        idx_d = idx_q + CW'(1);
        if (idx_q != '0 && hit) begin
          if (cnt_q == '0) found_d = 6'(idx_q - CW'(1));
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_SCAN_LAST: if (hit) begin
        if (cnt_q == '0) found_d = 6'(idx_q - CW'(1));
        cnt_d = cnt_q + 7'd1;
      end
      default: ;
    endcase
    if (behind_q) begin
      res_d = '{status: StBehind, box_index: '0, enclosing_count: '0, pixel_u: '0,
                pixel_v: '0};
    end else begin
      res_d.status = (cnt_d == '0) ? StNone : ((cnt_d == 7'd1) ? StOne : StMany);
      res_d.box_index = (cnt_d == 7'd1) ? found_d : '0;
      res_d.enclosing_count = cnt_d;
      res_d.pixel_u = u_d;
      res_d.pixel_v = v_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      mstep_q <= '0;
      div_sel_q <= 1'b0;
    end else begin
      st_q <= st_d;
      mstep_q <= mstep_d;
      div_sel_q <= div_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) item_q <= in_item_i;
    if (st_q == S_DIV_START) n_q <= n_eff;
    for (int i = 0; i < 3; i++) acc_q[i] <= acc_d[i];
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    found_q <= found_d;
    behind_q <= behind_d;
    u_q <= u_d;
    v_q <= v_d;
    if (st_q != S_OUT) res_q <= res_d;
  end

  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign out_item_o = res_q;

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output both open");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == StOne |-> out_item_o.enclosing_count == 7'd1)
    else $error("single hit count wrong");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o)) else $error("result changed");
`endif

endmodule

// File: bench/lpra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpra_checker
// Watches the configuration port and both item channels of the lidar point
// to image box association block. It keeps its own box table and registers,
// predicts the result of each point item and compares every result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lpra_checker import lpra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_item_t          out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [63:0] matrix_q [6];
  logic [8:0]  shrink_q;
  logic [6:0]  active_q;
  box_t        box_table [64];
  out_item_t   expected_results [$];

  function automatic longint coef(int row, int k);
    logic [63:0] word;
    word = matrix_q[row * 2 + k / 2];
    return longint'($signed(k % 2 ? word[63:32] : word[31:0]));
  endfunction

  function automatic longint project_row(int row, in_item_t it);
    return coef(row, 0) * longint'(it.point_x) + coef(row, 1) * longint'(it.point_y)
         + coef(row, 2) * longint'(it.point_z) + coef(row, 3) * 256;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic box_t shrink_box(in_item_t it);
    int unsigned f;
    box_t b;
    f = (shrink_q > 256) ? 256 : shrink_q;
    b.left   = 13'(it.box_left + ((f * it.box_width) >> 9));
    b.top    = 13'(it.box_top + ((f * it.box_height) >> 9));
    b.width  = 12'((it.box_width * (256 - f)) >> 8);
    b.height = 12'((it.box_height * (256 - f)) >> 8);
    return b;
  endfunction

  function automatic out_item_t associate_point(in_item_t it);
    longint depth;
    int u;
    int v;
    int n;
    int count;
    int first;
    out_item_t r;
    r = '0;
    depth = project_row(2, it);
    if (depth <= 0) begin
      r.status = StBehind;
      return r;
    end
    r.pixel_u = clamp16(project_row(0, it) / depth);
    r.pixel_v = clamp16(project_row(1, it) / depth);
    u = r.pixel_u;
    v = r.pixel_v;
    n = (active_q > 64) ? 64 : active_q;
    count = 0;
    first = 0;
    for (int i = 0; i < n; i++) begin
      if (int'(box_table[i].left) <= u && u < int'(box_table[i].left) + int'(box_table[i].width)
          && int'(box_table[i].top) <= v
          && v < int'(box_table[i].top) + int'(box_table[i].height)) begin
        if (count == 0) first = i;
        count++;
      end
    end
    r.status = (count == 0) ? StNone : ((count == 1) ? StOne : StMany);
    r.box_index = (count == 1) ? 6'(first) : 6'd0;
    r.enclosing_count = (count > 127) ? 7'd127 : 7'(count);
    return r;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) matrix_q[i] = '0;
      shrink_q = '0;
      active_q = '0;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegShrink: shrink_q = cfg_data_i[8:0];
          RegActive: active_q = cfg_data_i[6:0];
          default: matrix_q[cfg_idx_i] = cfg_data_i;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: %p", out_item_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item_i.status);
            fail_count_o++;
          end
          if (out_item_i.box_index !== want.box_index) begin
            $error("box_index: expected %0d, got %0d", want.box_index, out_item_i.box_index);
            fail_count_o++;
          end
          if (out_item_i.enclosing_count !== want.enclosing_count) begin
            $error("enclosing_count: expected %0d, got %0d", want.enclosing_count,
                   out_item_i.enclosing_count);
            fail_count_o++;
          end
          if (out_item_i.pixel_u !== want.pixel_u) begin
            $error("pixel_u: expected %0d, got %0d", want.pixel_u, out_item_i.pixel_u);
            fail_count_o++;
          end
          if (out_item_i.pixel_v !== want.pixel_v) begin
            $error("pixel_v: expected %0d, got %0d", want.pixel_v, out_item_i.pixel_v);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.func == FuncLoad) box_table[in_item_i.box_slot] = shrink_box(in_item_i);
        else expected_results = {expected_results, associate_point(in_item_i)};
      end
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the association block through several register settings with box
// loads and lidar points, under random sender gaps and receiver stalls, and
// gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
  import lpra_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  int                 fail_count;
  int                 pending;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  bit                 stall_mode = 1'b0;

  localparam int WatchdogLimit = 20000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lidar_point_roi_association DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_valid_i, .in_ready_o,
    .in_item_i, .out_valid_o, .out_ready_i, .out_item_o
  );

  lpra_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_valid_i,
    .in_ready_i(in_ready_o), .in_item_i, .out_valid_i(out_valid_o), .out_ready_i,
    .out_item_i(out_item_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= ~stall_mode;
    out_ready_i <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && pending == 0)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  function automatic in_item_t load_item(int slot);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.func = FuncLoad;
    it.box_slot = (slot < 0) ? 6'($urandom) : 6'(slot);
    return it;
  endfunction

  function automatic in_item_t point_item(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.func = FuncPoint;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    return it;
  endfunction

  // Window projection: u = x/16 + 2048, v = y/16 + 2048 with a constant depth.
  task automatic set_window_matrix();
    write_reg(RegRow0Lo, {32'd0, 32'(16 << 16)});
    write_reg(RegRow0Hi, {32'(2048 << 16), 32'd0});
    write_reg(RegRow1Lo, {32'(16 << 16), 32'd0});
    write_reg(RegRow1Hi, {32'(2048 << 16), 32'd0});
    write_reg(RegRow2Lo, 64'd0);
    write_reg(RegRow2Hi, {32'(1 << 16), 32'd0});
  endtask

  initial begin
    int unsigned shrink_set [5] = '{0, 256, 511, 128, 37};
    int unsigned active_set [5] = '{64, 0, 127, 1, 33};
    logic signed [15:0] corner [3] = '{16'sh8000, 16'sh7fff, 16'sh0000};
    int mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(RegShrink, 64'd0);
    write_reg(RegActive, 64'd64);
    set_window_matrix();
    for (int s = 0; s < 64; s++) send_item(load_item(s));
    send_item(point_item(16'sh0000, 16'sh0000, 16'sh0000));
    foreach (corner[i]) foreach (corner[j])
      send_item(point_item(corner[i], corner[j], corner[(i + j) % 3]));
    drain_block();

    for (int phase = 0; phase < 10; phase++) begin
      drain_block();
      write_reg(RegShrink, 64'(phase < 5 ? shrink_set[phase] : $urandom_range(0, 511)));
      write_reg(RegActive, 64'(phase < 5 ? active_set[phase] : $urandom_range(0, 127)));
      mode = phase % 4;
      if (mode == 0) set_window_matrix();
      else if (mode == 1) begin
        write_reg(RegRow0Lo, {$urandom, $urandom});
        write_reg(RegRow0Hi, {$urandom, $urandom});
        write_reg(RegRow1Lo, {$urandom, $urandom});
        write_reg(RegRow1Hi, {$urandom, $urandom});
        write_reg(RegRow2Lo, {32'd0, 32'(1 << 16)});
        write_reg(RegRow2Hi, 64'd0);
      end else if (mode == 2) begin
        for (int r = 0; r < 6; r++) write_reg(r[CfgIdxW-1:0], {$urandom, $urandom});
      end else begin
        for (int r = 0; r < 6; r++)
          write_reg(r[CfgIdxW-1:0], r % 2 ? 64'h7fffffff_80000000 : 64'h80000000_7fffffff);
      end
      for (int n = 0; n < 80; n++) begin
        if (n == 40 && phase % 3 == 0) drain_block();
        if ($urandom_range(0, 3) == 0) send_item(load_item(-1));
        else if (mode == 0)
          send_item(point_item(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom)));
        else send_item(point_item(16'($urandom), 16'($urandom), 16'($urandom)));
      end
      in_valid_i <= 1'b0;
      burst_left = 0;
    end

    drain_block();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: lidar_point_roi_association.f
hdl/lpra_pkg.sv
hdl/lpra_div.sv
hdl/lidar_point_roi_association.sv
bench/lpra_checker.sv
bench/tb_top.sv
